### rtl/jsd_pkg.sv
// Package for the justify space distributor.
// Holds widths, CSR indices, controller states, command and status structs, reset and seed constants.
// No dependencies.
package jsd_pkg;

   localparam int MAX_SPACES_DEFAULT = 64;

   localparam int COUNT_W = 7;
   localparam int PIX_W = 12;
   localparam int MIN_W = 8;
   localparam int INDEX_W = 6;
   localparam int SEED_W = 16;
   localparam int DIV_CNT_W = 4;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPACE_WIDTH = 1'd1;

   localparam logic [PIX_W-1:0] AREA_WIDTH_RESET = 12'd320;
   localparam logic [MIN_W-1:0] MIN_SPACE_WIDTH_RESET = 8'd2;

   localparam logic [SEED_W-1:0] SEED_MUL = 16'd17;
   localparam logic [SEED_W-1:0] SEED_ADD = 16'd87;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_FREE,
      ST_CHECK,
      ST_SEED,
      ST_PICK_WAIT,
      ST_PICK_TEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start_free;
      logic div_start_seed;
      logic save_quot;
      logic mark_pick;
      logic out_ok_load;
      logic out_fail_load;
   } cmd_type;

   typedef struct packed {
      logic fail_early;
      logic base_low;
      logic extra_zero;
      logic extra_one;
      logic div_busy;
      logic pick_taken;
      logic idx_last;
      logic out_free;
   } status_type;

endpackage

### rtl/jsd_ctrl.sv
// Controller state machine of the justify space distributor.
// Sequences division, space picking and result emission; depends on jsd_pkg.
module jsd_ctrl
   import jsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      fail_ff;
   logic      fail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fail_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fail_ff <= fail_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fail_in = fail_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
               fail_in = 1'b0;
            end
         end
         ST_PREP: begin
            if (status.fail_early) begin
               state_in = ST_EMIT;
               fail_in = 1'b1;
            end else begin
               state_in = ST_DIV_FREE;
            end
         end
         ST_DIV_FREE: begin
            if (!status.div_busy) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.base_low) begin
               state_in = ST_EMIT;
               fail_in = 1'b1;
            end else if (status.extra_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            state_in = ST_PICK_WAIT;
         end
         ST_PICK_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_PICK_TEST;
            end
         end
         ST_PICK_TEST: begin
            if (!status.pick_taken && status.extra_one) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SEED;
            end
         end
         ST_EMIT: begin
            if (status.out_free && (fail_ff || status.idx_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_PREP: begin
            cmd.div_start_free = !status.fail_early;
         end
         ST_DIV_FREE: begin
            cmd.save_quot = !status.div_busy;
         end
         ST_SEED: begin
            cmd.div_start_seed = 1'b1;
         end
         ST_PICK_TEST: begin
            cmd.mark_pick = !status.pick_taken;
         end
         ST_EMIT: begin
            cmd.out_fail_load = status.out_free && fail_ff;
            cmd.out_ok_load = status.out_free && !fail_ff;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/jsd_datapath.sv
// Datapath of the justify space distributor: configuration registers, shared
// restoring divider, pick generator, widened-space flags and result register.
// Depends on jsd_pkg; driven by jsd_ctrl.
module jsd_datapath
   import jsd_pkg::*;
#(
   parameter int MAX_SPACES = MAX_SPACES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [COUNT_W-1:0]    req_space_count,
   input  logic [PIX_W-1:0]      req_text_width,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output logic [INDEX_W-1:0]    rsp_gap_index,
   output logic [PIX_W-1:0]      rsp_gap_width,
   output logic                  rsp_last,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int IDX_W = (MAX_SPACES > 1) ? $clog2(MAX_SPACES) : 1;
   localparam logic [8:0] MAX_SP = 9'(MAX_SPACES);

   logic [PIX_W-1:0]      area_ff;
   logic [MIN_W-1:0]      min_ff;
   logic [COUNT_W-1:0]    spaces_ff;
   logic [PIX_W-1:0]      text_ff;
   logic [PIX_W-1:0]      base_ff;
   logic [COUNT_W-1:0]    extra_ff;
   logic [SEED_W-1:0]     seed_ff;
   logic [SEED_W-1:0]     seed_in;
   logic [MAX_SPACES-1:0] mask_ff;
   logic [COUNT_W-1:0]    idx_ff;

   logic                  div_busy_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [SEED_W-1:0]     quo_ff;
   logic [COUNT_W-1:0]    rem_ff;
   logic [COUNT_W:0]      partial;
   logic                  div_ge;
   logic [COUNT_W-1:0]    rem_in;
   logic [SEED_W-1:0]     quo_in;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [PIX_W-1:0]      rsp_width_ff;
   logic                  rsp_last_ff;

   logic [PIX_W-1:0]      free_px;
   logic [IDX_W-1:0]      pick_idx;
   logic [IDX_W-1:0]      emit_idx;
   logic                  out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff <= AREA_WIDTH_RESET;
         min_ff <= MIN_SPACE_WIDTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AREA_WIDTH: area_ff <= csr_wdata;
            CSR_MIN_SPACE_WIDTH: min_ff <= csr_wdata[MIN_W-1:0];
            default: area_ff <= area_ff;
         endcase
      end
   end

   assign free_px = PIX_W'(area_ff - text_ff - 12'd1);
   assign seed_in = SEED_W'(seed_ff * SEED_MUL + SEED_ADD);
   assign pick_idx = IDX_W'(rem_ff);
   assign emit_idx = IDX_W'(idx_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign partial = {rem_ff, quo_ff[SEED_W-1]};
   assign div_ge = partial >= {1'b0, spaces_ff};
   assign rem_in = div_ge ? COUNT_W'(partial - {1'b0, spaces_ff}) : partial[COUNT_W-1:0];
   assign quo_in = {quo_ff[SEED_W-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else if (cmd.div_start_free || cmd.div_start_seed) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= DIV_CNT_W'(div_cnt_ff + 1'b1);
         if (div_cnt_ff == '1) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start_free) begin
         quo_ff <= {{(SEED_W-PIX_W){1'b0}}, free_px};
         rem_ff <= '0;
      end else if (cmd.div_start_seed) begin
         quo_ff <= seed_in;
         rem_ff <= '0;
      end else if (div_busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         spaces_ff <= req_space_count;
         text_ff <= req_text_width;
         seed_ff <= '0;
         mask_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cmd.save_quot) begin
            base_ff <= quo_ff[PIX_W-1:0];
            extra_ff <= rem_ff;
         end
         if (cmd.div_start_seed) begin
            seed_ff <= seed_in;
         end
         if (cmd.mark_pick) begin
            mask_ff[pick_idx] <= 1'b1;
            extra_ff <= COUNT_W'(extra_ff - 1'b1);
         end
         if (cmd.out_ok_load) begin
            idx_ff <= COUNT_W'(idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ok_load || cmd.out_fail_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ok_load) begin
         rsp_ok_ff <= 1'b1;
         rsp_index_ff <= idx_ff[INDEX_W-1:0];
         rsp_width_ff <= PIX_W'(base_ff + {{(PIX_W-1){1'b0}}, mask_ff[emit_idx]});
         rsp_last_ff <= status.idx_last;
      end else if (cmd.out_fail_load) begin
         rsp_ok_ff <= 1'b0;
         rsp_index_ff <= '0;
         rsp_width_ff <= '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_gap_index = rsp_index_ff;
   assign rsp_gap_width = rsp_width_ff;
   assign rsp_last = rsp_last_ff;

   always_comb begin
      status.fail_early = (spaces_ff == '0) || ({2'b00, spaces_ff} > MAX_SP)
                          || ({1'b0, area_ff} <= ({1'b0, text_ff} + 13'd1));
      status.base_low = base_ff < {{(PIX_W-MIN_W){1'b0}}, min_ff};
      status.extra_zero = extra_ff == '0;
      status.extra_one = extra_ff == 7'd1;
      status.div_busy = div_busy_ff;
      status.pick_taken = mask_ff[pick_idx];
      status.idx_last = idx_ff == COUNT_W'(spaces_ff - 1'b1);
      status.out_free = out_free;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cmd.mark_pick |-> !mask_ff[pick_idx])
      else $error("A space was widened twice.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start_free || cmd.div_start_seed) |-> !div_busy_ff)
      else $error("Divider restarted while busy.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_ok_load || cmd.out_fail_load) |-> out_free)
      else $error("Result register overwritten before it was taken.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.mark_pick || cmd.div_start_seed) |-> (extra_ff != '0))
      else $error("Pick issued with no extra pixels left.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_last_ff && rsp_index_ff == '0
                                        && rsp_width_ff == '0))
      else $error("Failure transaction carries nonzero fields.");
`endif

endmodule

### rtl/justify_space_distributor_core.sv
// Top level of the justify space distributor.
// Instantiates jsd_ctrl and jsd_datapath; depends on jsd_pkg.
//
// Each request transaction describes one text line and produces either one
// failure transaction (ok low) or one transaction per space in index order,
// the last one flagged. A request is accepted only while the block is idle.
// One restoring divider is shared by all work: a line first takes setup and
// the base width division, then generator steps, each with a division, while
// picking the spaces that get an extra pixel (including steps that land on an
// already widened space), then one space transaction per cycle while the
// consumer keeps rsp_ready high.
module justify_space_distributor_core
   import jsd_pkg::*;
#(
   parameter int MAX_SPACES = MAX_SPACES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COUNT_W-1:0]    req_space_count,
   input  logic [PIX_W-1:0]      req_text_width,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output logic [INDEX_W-1:0]    rsp_gap_index,
   output logic [PIX_W-1:0]      rsp_gap_width,
   output logic                  rsp_last
);

   cmd_type    cmd;
   status_type status;

   jsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   jsd_datapath #(
      .MAX_SPACES (MAX_SPACES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_space_count (req_space_count),
      .req_text_width  (req_text_width),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_gap_index   (rsp_gap_index),
      .rsp_gap_width   (rsp_gap_width),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
